// ----- hdl/hcbp_pkg.sv -----
// Shared types and constants of the Huffman code bit packer.
`timescale 1ns / 1ps

package hcbp_pkg;

  localparam int CODE_W = 32;
  localparam int LEN_W = 6;
  localparam int IDX_W = 11;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_ENCODE = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;

  localparam logic [IDX_W-1:0] END_SYMBOL = 11'd256;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [LEN_W-1:0] len;
  } entry_t;

  typedef struct packed {
    logic wr;
    logic rd;
    logic align;
    logic step;
    logic flush;
  } cmd_t;

  typedef struct packed {
    logic rem_zero;
    logic byte_full;
    logic out_free;
    logic cnt_zero;
    logic finish;
  } stat_t;

endpackage

// ----- hdl/huffman_code_bit_packer_core.sv -----
// Top level of the Huffman code bit packer: controller and datapath.
//
//   channel  direction  handshake             word
//   input    in         in_valid / in_ready   mode, symbol, code_bits, code_length
//   output   out        out_valid / out_ready out_byte, last_of_run, end_of_stream
//
// A load writes the code table entry. An encode or finish reads the table, aligns the
// code and packs it in bit chunks (one chunk per output byte or partial byte, at most
// 5); a finish then flushes a partial byte, if one is left, to the output.
// Reset clears the accumulator, count and control; the code table is not cleared.
// A full output register that is not taken holds the packing step.
`timescale 1ns / 1ps

module huffman_code_bit_packer_core #(
  parameter int MAX_CODE_LEN = 32,
  parameter int NUM_SYMBOLS = 257
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  mode,
  input  logic [8:0]  symbol,
  input  logic [31:0] code_bits,
  input  logic [5:0]  code_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte,
  output logic        last_of_run,
  output logic        end_of_stream
);

  hcbp_pkg::cmd_t  cmd;
  hcbp_pkg::stat_t stat;

  hcbp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .stat     (stat),
    .cmd      (cmd)
  );

  hcbp_datapath #(
    .MAX_CODE_LEN (MAX_CODE_LEN),
    .NUM_SYMBOLS  (NUM_SYMBOLS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .mode          (mode),
    .symbol        (symbol),
    .code_bits     (code_bits),
    .code_length   (code_length),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .last_of_run   (last_of_run),
    .end_of_stream (end_of_stream)
  );

endmodule

// ----- hdl/hcbp_ctrl.sv -----
// Controller state machine of the Huffman code bit packer.
`timescale 1ns / 1ps

module hcbp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [1:0]       mode,
  input  hcbp_pkg::stat_t  stat,
  output hcbp_pkg::cmd_t   cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ALIGN = 2'd1;
  localparam logic [1:0] S_PACK = 2'd2;
  localparam logic [1:0] S_FLUSH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_ready = (state == S_IDLE);
  assign accept = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          priority if (mode == hcbp_pkg::MODE_LOAD) begin
            cmd.wr = 1'b1;
          end else if (mode == hcbp_pkg::MODE_ENCODE || mode == hcbp_pkg::MODE_FINISH) begin
            cmd.rd = 1'b1;
            state_next = S_ALIGN;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      S_ALIGN: begin
        cmd.align = 1'b1;
        state_next = S_PACK;
      end
      S_PACK: begin
        priority if (stat.rem_zero) begin
          if (stat.finish && !stat.cnt_zero) begin
            state_next = S_FLUSH;
          end else begin
            state_next = S_IDLE;
          end
        end else if (!stat.byte_full || stat.out_free) begin
          cmd.step = 1'b1;
        end else begin
          state_next = S_PACK;
        end
      end
      S_FLUSH: begin
        if (stat.out_free) begin
          cmd.flush = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/hcbp_datapath.sv -----
// Code table, bit accumulator and output register of the Huffman code bit packer.
`timescale 1ns / 1ps

module hcbp_datapath #(
  parameter int MAX_CODE_LEN = 32,
  parameter int NUM_SYMBOLS = 257
) (
  input  logic             clk,
  input  logic             rst,
  input  hcbp_pkg::cmd_t   cmd,
  output hcbp_pkg::stat_t  stat,
  input  logic [1:0]       mode,
  input  logic [8:0]       symbol,
  input  logic [31:0]      code_bits,
  input  logic [5:0]       code_length,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [7:0]       out_byte,
  output logic             last_of_run,
  output logic             end_of_stream
);

  localparam int AW = $clog2(NUM_SYMBOLS);

  hcbp_pkg::entry_t mem [NUM_SYMBOLS];
  hcbp_pkg::entry_t rd_entry;

  logic [hcbp_pkg::IDX_W-1:0] wr_idx;
  logic [hcbp_pkg::IDX_W-1:0] look_idx;
  logic                       load_ok;
  logic                       look_ok;
  logic                       look_ok_q;
  logic                       finish;

  logic [31:0] cod;
  logic [5:0]  rem;
  logic [7:0]  acc;
  logic [2:0]  cnt;

  logic [3:0]  room;
  logic [3:0]  take;
  logic [7:0]  acc_or;
  logic [3:0]  cnt_sum;
  logic        byte_full;
  logic        last_chunk;
  logic        out_free;
  logic [5:0]  shamt;

  assign wr_idx = hcbp_pkg::IDX_W'(symbol);
  assign look_idx = (mode == hcbp_pkg::MODE_FINISH) ? hcbp_pkg::END_SYMBOL
                                                    : hcbp_pkg::IDX_W'(symbol[7:0]);
  assign load_ok = (wr_idx < hcbp_pkg::IDX_W'(NUM_SYMBOLS))
                && ({1'b0, code_length} <= 7'(MAX_CODE_LEN))
                && (code_length <= 6'd32);
  assign look_ok = look_idx < hcbp_pkg::IDX_W'(NUM_SYMBOLS);

  always_ff @(posedge clk) begin
    if (cmd.wr && load_ok) begin
      mem[wr_idx[AW-1:0]] <= '{code: code_bits, len: code_length};
    end
    if (cmd.rd) begin
      rd_entry <= mem[look_idx[AW-1:0]];
    end
  end

  assign room = 4'd8 - {1'b0, cnt};
  assign byte_full = {2'b00, room} <= rem;
  assign take = byte_full ? room : rem[3:0];
  assign acc_or = acc | (cod[31:24] >> cnt);
  assign cnt_sum = {1'b0, cnt} + take;
  assign last_chunk = finish ? ({2'b00, room} == rem)
                             : (({2'b00, room} + 6'd8) > rem);
  assign out_free = !out_valid || out_ready;
  assign shamt = 6'd32 - rd_entry.len;

  assign stat.rem_zero = (rem == 6'd0);
  assign stat.byte_full = byte_full;
  assign stat.out_free = out_free;
  assign stat.cnt_zero = (cnt == 3'd0);
  assign stat.finish = finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      acc <= '0;
      cnt <= '0;
      rem <= '0;
      finish <= 1'b0;
      look_ok_q <= 1'b0;
    end else begin
      if (cmd.rd) begin
        finish <= (mode == hcbp_pkg::MODE_FINISH);
        look_ok_q <= look_ok;
      end
      if (cmd.align) begin
        cod <= rd_entry.code << shamt;
        rem <= look_ok_q ? rd_entry.len : 6'd0;
      end
      if (cmd.step) begin
        cod <= cod << take;
        rem <= rem - {2'b00, take};
        if (byte_full) begin
          acc <= '0;
          cnt <= '0;
        end else begin
          acc <= acc_or;
          cnt <= cnt_sum[2:0];
        end
      end
      if (cmd.flush) begin
        acc <= '0;
        cnt <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((cmd.step && byte_full) || cmd.flush) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && byte_full) begin
      out_byte <= acc_or;
      last_of_run <= last_chunk;
      end_of_stream <= finish && last_chunk;
    end else if (cmd.flush) begin
      out_byte <= acc;
      last_of_run <= 1'b1;
      end_of_stream <= 1'b1;
    end
  end

endmodule
